FILE: hw/rtl/gscb_pkg.sv
// gscb_pkg: shared types, widths and the gamma re-encode threshold table
// for the gamma-2 crossfade pipeline. No dependencies.
package gscb_pkg;

  localparam int Channels = 4;
  localparam int ByteW    = 8;
  localparam int LinW     = 16;
  localparam int MixW     = 9;
  localparam int SumW     = 25;
  localparam int ThrW     = 17;
  localparam int BitIdxW  = 3;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic [MixW-1:0]  MixFull   = 9'd256;
  localparam logic [AddrW-1:0] RegMixSel = 3'd0;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [LinW-1:0]  lin_t;

  // linear values of both pixels after gamma expansion
  typedef struct packed {
    lin_t [Channels-1:0] lin_a;
    lin_t [Channels-1:0] lin_b;
    logic                frame_end;
  } exp_t;

  // blended linear value and the partially resolved output byte
  typedef struct packed {
    lin_t  [Channels-1:0] col;
    byte_t [Channels-1:0] res;
    logic                 frame_end;
  } root_t;

  // out = floor(65535.99*sqrt(col/65535)) >> 8 is the largest o with
  // (256*o)^2 * 65535 * 10000 <= 6553599^2 * col, i.e. col >= thr[o]
  localparam logic [63:0] NumScale = 64'd6553599 * 64'd6553599;
  localparam logic [63:0] DenScale = 64'd655350000;

  typedef logic [255:0][ThrW-1:0] thr_arr_t;

  function automatic thr_arr_t build_thr();
    thr_arr_t    t;
    logic [63:0] x;
    for (int o = 0; o < 256; o++) begin
      x    = 64'(o) * 64'd256;
      x    = x * x * DenScale;
      t[o] = ThrW'((x + NumScale - 64'd1) / NumScale);
    end
    return t;
  endfunction

  localparam thr_arr_t ThrTable = build_thr();

endpackage

FILE: hw/rtl/gscb_expand.sv
// gscb_expand: first pipeline stage, expands each channel byte of both
// pixels to its 16-bit linear value (v+1)^2-1. Uses gscb_pkg.
module gscb_expand import gscb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  byte_t [Channels-1:0] first_i,
  input  byte_t [Channels-1:0] second_i,
  input  logic                 frame_end_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output exp_t                 data_o
);

  function automatic lin_t expand(input byte_t v);
    logic [ByteW:0]     b;
    logic [2*ByteW+1:0] sq;
    b  = {1'b0, v} + 9'd1;
    sq = b * b;
    return LinW'(sq - 18'd1);
  endfunction

  logic valid_q, valid_d;
  exp_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = ready_o ? valid_i : valid_q;
    data_d  = data_q;
    if (valid_i && ready_o) begin
      for (int ch = 0; ch < Channels; ch++) begin
        data_d.lin_a[ch] = expand(first_i[ch]);
        data_d.lin_b[ch] = expand(second_i[ch]);
      end
      data_d.frame_end = frame_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/gscb_blend.sv
// gscb_blend: second pipeline stage, weights the two linear values and
// keeps bits 23..8 of the sum, saturating on overflow. Uses gscb_pkg.
module gscb_blend import gscb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  exp_t            data_i,
  input  logic [MixW-1:0] w1_i,
  input  logic [MixW-1:0] w2_i,
  output logic            valid_o,
  input  logic            ready_i,
  output root_t           data_o
);

  logic  valid_q, valid_d;
  root_t data_q, data_d;
  logic  [SumW-1:0] sum [Channels];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = ready_o ? valid_i : valid_q;
    data_d  = data_q;
    for (int ch = 0; ch < Channels; ch++) begin
      sum[ch] = SumW'(w1_i) * SumW'(data_i.lin_a[ch])
              + SumW'(w2_i) * SumW'(data_i.lin_b[ch]);
    end
    if (valid_i && ready_o) begin
      for (int ch = 0; ch < Channels; ch++) begin
        // top bit set means the blend left the 16-bit range
        data_d.col[ch] = sum[ch][SumW-1] ? '1 : sum[ch][SumW-2:8];
        data_d.res[ch] = '0;
      end
      data_d.frame_end = data_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/gscb_root_step.sv
// gscb_root_step: one stage of the square-root search, resolves one bit of
// the output byte by comparing against the threshold table. Uses gscb_pkg.
module gscb_root_step import gscb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BitIdxW-1:0] bit_idx_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  root_t              data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output root_t              data_o
);

  logic  valid_q, valid_d;
  root_t data_q, data_d;
  byte_t cand [Channels];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = ready_o ? valid_i : valid_q;
    data_d  = data_q;
    for (int ch = 0; ch < Channels; ch++) begin
      cand[ch] = data_i.res[ch] | (byte_t'(1) << bit_idx_i);
    end
    if (valid_i && ready_o) begin
      data_d = data_i;
      for (int ch = 0; ch < Channels; ch++) begin
        if ({1'b0, data_i.col[ch]} >= ThrTable[cand[ch]]) begin
          data_d.res[ch] = cand[ch];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/gamma_space_crossfade_byte.sv
// gamma_space_crossfade_byte: top level of the gamma-2 crossfade pipeline.
// Depends on gscb_pkg, gscb_expand, gscb_blend and gscb_root_step.
//
// Crossfades two RGBA pixels in linear light. A request on the input channel
// (in_valid_i/in_ready_o) carries the channel bytes of both pixels and a
// last-in-frame marker; the result channel (out_valid_o/out_ready_i) returns
// the four re-encoded bytes and the marker copy, one result per request.
// The weight mix_factor is written over the APB port at byte address 0;
// values above 256 act as 256. Write it only while the pipeline is empty.
// It has one expand stage, one blend stage (two 9x16 multiplies per channel)
// and eight square-root stages, one output bit each. Throughput is one
// pixel per cycle unless out_ready_i is low. Every stage has its own valid
// and takes a new request as soon as its contents move on, so bubbles
// close up while the receiver stalls and nothing is lost or repeated.
// Reset clears all valid bits and sets mix_factor to 0.
module gamma_space_crossfade_byte import gscb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       first_ch0_i,
  input  logic [7:0]       first_ch1_i,
  input  logic [7:0]       first_ch2_i,
  input  logic [7:0]       first_ch3_i,
  input  logic [7:0]       second_ch0_i,
  input  logic [7:0]       second_ch1_i,
  input  logic [7:0]       second_ch2_i,
  input  logic [7:0]       second_ch3_i,
  input  logic             frame_end_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       mixed_ch0_o,
  output logic [7:0]       mixed_ch1_o,
  output logic [7:0]       mixed_ch2_o,
  output logic [7:0]       mixed_ch3_o,
  output logic             frame_end_out_o
);

  localparam int Steps = 8;

  // configuration register
  logic [MixW-1:0] mix_q, mix_d;
  logic [MixW-1:0] w1, w2;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrW-1] == RegMixSel[AddrW-1]);
  assign mix_d  = cfg_wr ? pwdata[MixW-1:0] : mix_q;
  assign prdata = (paddr[AddrW-1] == RegMixSel[AddrW-1]) ? DataW'(mix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q <= '0;
    end else begin
      mix_q <= mix_d;
    end
  end

  assign w2 = (mix_q > MixFull) ? MixFull : mix_q;
  assign w1 = MixFull - w2;

  // input lanes
  byte_t [3:0] first_all, second_all;
  byte_t [Channels-1:0] first_in, second_in;

  assign first_all  = {first_ch3_i, first_ch2_i, first_ch1_i, first_ch0_i};
  assign second_all = {second_ch3_i, second_ch2_i, second_ch1_i, second_ch0_i};
  assign first_in   = first_all[Channels-1:0];
  assign second_in  = second_all[Channels-1:0];

  logic  exp_valid, exp_ready;
  exp_t  exp_data;
  logic  stg_valid [Steps+1];
  logic  stg_ready [Steps+1];
  root_t stg_data  [Steps+1];

  gscb_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .first_i     (first_in),
    .second_i    (second_in),
    .frame_end_i (frame_end_in_i),
    .valid_o     (exp_valid),
    .ready_i     (exp_ready),
    .data_o      (exp_data)
  );

  gscb_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exp_valid),
    .ready_o (exp_ready),
    .data_i  (exp_data),
    .w1_i    (w1),
    .w2_i    (w2),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  // msb first: step k decides output bit Steps-1-k
  for (genvar k = 0; k < Steps; k++) begin : g_step
    gscb_root_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bit_idx_i (BitIdxW'(Steps - 1 - k)),
      .valid_i   (stg_valid[k]),
      .ready_o   (stg_ready[k]),
      .data_i    (stg_data[k]),
      .valid_o   (stg_valid[k+1]),
      .ready_i   (stg_ready[k+1]),
      .data_o    (stg_data[k+1])
    );
  end

  assign stg_ready[Steps] = out_ready_i;
  assign out_valid_o      = stg_valid[Steps];
  assign frame_end_out_o  = stg_data[Steps].frame_end;

  byte_t [3:0] mixed_all;

  for (genvar ch = 0; ch < 4; ch++) begin : g_out
    if (ch < Channels) begin : g_used
      assign mixed_all[ch] = stg_data[Steps].res[ch];
    end else begin : g_unused
      assign mixed_all[ch] = '0;
    end
  end

  assign mixed_ch0_o = mixed_all[0];
  assign mixed_ch1_o = mixed_all[1];
  assign mixed_ch2_o = mixed_all[2];
  assign mixed_ch3_o = mixed_all[3];

  // an empty output stage must never hold back the input
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> mix_q == $past(pwdata[MixW-1:0]))
    else $error("mix_factor write lost");

  a_weights : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w1 + w2 == MixFull) && (w2 <= MixFull))
    else $error("blend weights do not sum to full");

  a_cfg_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[AddrW-1] == RegMixSel[AddrW-1])
      |-> prdata[MixW-1:0] == mix_q)
    else $error("mix_factor readback mismatch");

endmodule
